FILE: rtl/fixed_block_pool_allocator_top_macros.svh
// Assertion macros for the fixed block pool allocator.
// Used by fixed_block_pool_allocator_top; no other dependencies.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define FBPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package fbpa_pkg;

   localparam int ADDR_W        = 48;
   localparam int SIZE_W        = 17;
   localparam int COUNT_W       = 11;
   localparam int REQ_W         = 32;
   localparam int LEN_W         = 32;
   localparam int DIV_Q_W       = 11;
   localparam int PROD_W        = SIZE_W + DIV_Q_W;
   localparam int CSR_IDX_W     = 2;
   localparam int SIZE_WHEN_ZERO = 2048;
   localparam int RESET_SIZE    = 2048;
   localparam int RESET_COUNT   = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_NO_BLOCK      = 3'd1,
      ST_SIZE_MISMATCH = 3'd2,
      ST_OUT_OF_RANGE  = 3'd3,
      ST_STACK_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      logic               pop;
      logic               push;
      logic               refill;
      logic [COUNT_W-1:0] refill_count;
   } stack_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stack_stat_type;

endpackage

`default_nettype wire

FILE: rtl/fbpa_stack.sv
// Free-entry stack: one synchronous memory, top pointer and low-water fill mark.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_stack #(
   parameter int  MAX_BLOCKS = 1024,
   localparam int EW         = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fbpa_pkg::stack_cmd_type       cmd,
   input  logic [fbpa_pkg::COUNT_W-1:0]  block_count,
   input  logic [EW-1:0]                 push_data,
   output logic [EW-1:0]                 pop_data,
   output fbpa_pkg::stack_stat_type      stat
);
   import fbpa_pkg::*;

   localparam int TOP_W   = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W   = (TOP_W > COUNT_W) ? TOP_W : COUNT_W;
   localparam int RST_TOP = (RESET_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : RESET_COUNT;

   logic [EW-1:0]    free_mem [MAX_BLOCKS];
   logic [TOP_W-1:0] top_ff, top_in;
   logic [TOP_W-1:0] lwm_ff, lwm_in;
   logic [TOP_W-1:0] below_top;
   logic [EW-1:0]    rd_q_ff;
   logic [EW-1:0]    ident_idx_ff;
   logic             ident_ff;

   assign below_top = top_ff - TOP_W'(1);

   always_comb begin
      top_in = top_ff;
      lwm_in = lwm_ff;
      if (cmd.refill) begin
         top_in = TOP_W'(cmd.refill_count);
         lwm_in = TOP_W'(cmd.refill_count);
      end else if (cmd.pop) begin
         top_in = below_top;
         if (below_top < lwm_ff) begin
            lwm_in = below_top;
         end
      end else if (cmd.push) begin
         top_in = top_ff + TOP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= TOP_W'(RST_TOP);
         lwm_ff <= TOP_W'(RST_TOP);
      end else begin
         top_ff <= top_in;
         lwm_ff <= lwm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         free_mem[EW'(top_ff)] <= push_data;
      end
      if (cmd.pop) begin
         rd_q_ff <= free_mem[EW'(below_top)];
      end
   end

   // entries below the fill mark were never written since refill
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         ident_ff     <= (below_top < lwm_ff);
         ident_idx_ff <= EW'(below_top);
      end
   end

   assign pop_data   = ident_ff ? ident_idx_ff : rd_q_ff;
   assign stat.empty = (top_ff == '0);
   assign stat.full  = (CMP_W'(top_ff) >= CMP_W'(block_count));

endmodule

`default_nettype wire

FILE: rtl/fbpa_divider.sv
// Restoring divider, one quotient bit per cycle, for the block number of a free.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fbpa_pkg::PROD_W-1:0]   dividend,
   input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
   output logic                          done,
   output logic [fbpa_pkg::DIV_Q_W-1:0]  quotient
);
   import fbpa_pkg::*;

   localparam int CNT_W = $clog2(DIV_Q_W);

   logic [PROD_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_Q_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               active_ff, active_in;
   logic               done_ff, done_in;

   always_comb begin
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in    = dividend;
         dsr_in    = PROD_W'({divisor, {(DIV_Q_W-1){1'b0}}});
         cnt_in    = CNT_W'(DIV_Q_W - 1);
         active_in = 1'b1;
      end else if (active_ff) begin
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            quo_in = {quo_ff[DIV_Q_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[DIV_Q_W-2:0], 1'b0};
         end
         dsr_in = dsr_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: sequencer, config registers, result.
// Depends on fbpa_pkg, fbpa_stack, fbpa_divider and the assertion macro header.
`default_nettype none
`include "fixed_block_pool_allocator_top_macros.svh"

// Usage:
//   An item (req_action and its operands) is taken at a clock edge with start high
//   and busy low. Each item gives one result on the rsp_ ports, shown for exactly
//   one cycle with rsp_strobe high; the receiver cannot stall, and the next item
//   may be started in the cycle the result is shown.
//   Steps from accept to strobe; no new item is taken before the result is shown:
//     allocate granted (stack memory read, block multiply, base add),
//     free accepted (span multiply, range check, restoring divider with one
//     quotient bit per cycle, push), free rejected at the range or full check
//     and query (span multiply, check), early reject or unknown action (none).
//   Configuration writes (csr_) take effect at once; the user must make them only
//   while idle, which the block does not enforce. Writing block_count refills the
//   free stack in identity order. Reset: base 0, block size 2048, block count
//   min(1024, MAX_BLOCKS), all blocks free. The stack memory needs no clearing
//   pass: a low-water fill mark makes never-written entries read as their own index.
module fixed_block_pool_allocator_top #(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_action,
   input  logic [fbpa_pkg::REQ_W-1:0]       req_request_bytes,
   input  logic [fbpa_pkg::ADDR_W-1:0]      req_block_address,
   input  logic [fbpa_pkg::LEN_W-1:0]       req_block_length,
   output logic                             rsp_strobe,
   output logic [2:0]                       rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]      rsp_granted_address,
   output logic [fbpa_pkg::SIZE_W-1:0]      rsp_granted_bytes,
   output logic                             rsp_in_pool,
   input  logic                             csr_write_enable,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]      csr_write_data
);
   import fbpa_pkg::*;

   localparam int EW        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int MUL_A_W   = (EW > COUNT_W) ? EW : COUNT_W;
   localparam int RST_COUNT = (RESET_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : RESET_COUNT;

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_ALLOC_MUL = 6'b000010,
      S_ALLOC_ADD = 6'b000100,
      S_CALC      = 6'b001000,
      S_CHECK     = 6'b010000,
      S_DIVIDE    = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   action_type            action_ff, action_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  below_ff, below_in;
   logic [ADDR_W-1:0]     offset_ff, offset_in;
   logic [ADDR_W-1:0]     mul_ff, mul_in;

   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [SIZE_W-1:0]     bytes_ff, bytes_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    count_sat;
   logic                  csr_refill;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]     rsp_gaddr_ff, rsp_gaddr_in;
   logic [SIZE_W-1:0]     rsp_gbytes_ff, rsp_gbytes_in;
   logic                  rsp_in_pool_ff, rsp_in_pool_in;

   logic [SIZE_W-1:0]     eff_size;
   logic                  accept;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_A_W+SIZE_W-1:0] mul_prod;

   stack_cmd_type         stack_cmd;
   stack_stat_type        stack_stat;
   logic [EW-1:0]         pop_data;
   logic [EW-1:0]         push_data;

   logic                  div_start;
   logic                  div_done;
   logic [DIV_Q_W-1:0]    div_quotient;

   assign eff_size = (bytes_ff == '0) ? SIZE_W'(SIZE_WHEN_ZERO) : bytes_ff;
   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);

   assign count_sat = (32'(csr_write_data[COUNT_W-1:0]) > 32'(MAX_BLOCKS)) ?
                      COUNT_W'(MAX_BLOCKS) : csr_write_data[COUNT_W-1:0];

   assign mul_a    = (state_ff == S_ALLOC_MUL) ? MUL_A_W'(pop_data) : MUL_A_W'(count_ff);
   assign mul_prod = (MUL_A_W+SIZE_W)'(mul_a) * (MUL_A_W+SIZE_W)'(eff_size);
   assign push_data = EW'(div_quotient);

   always_comb begin
      base_in    = base_ff;
      bytes_in   = bytes_ff;
      count_in   = count_ff;
      csr_refill = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_POOL_BASE:   base_in  = csr_write_data;
            CSR_BLOCK_BYTES: bytes_in = csr_write_data[SIZE_W-1:0];
            CSR_BLOCK_COUNT: begin
               count_in   = count_sat;
               csr_refill = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      addr_in        = addr_ff;
      below_in       = below_ff;
      offset_in      = offset_ff;
      mul_in         = mul_ff;
      stack_cmd.refill       = csr_refill;
      stack_cmd.refill_count = count_sat;
      stack_cmd.pop  = 1'b0;
      stack_cmd.push = 1'b0;
      div_start      = 1'b0;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_gaddr_in   = rsp_gaddr_ff;
      rsp_gbytes_in  = rsp_gbytes_ff;
      rsp_in_pool_in = rsp_in_pool_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               action_in      = action_type'(req_action);
               addr_in        = req_block_address;
               below_in       = (req_block_address < base_ff);
               rsp_status_in  = ST_OK;
               rsp_gaddr_in   = '0;
               rsp_gbytes_in  = '0;
               rsp_in_pool_in = 1'b0;
               case (action_type'(req_action))
                  ACT_ALLOC: begin
                     if (stack_stat.empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NO_BLOCK;
                     end else if (req_request_bytes > REQ_W'(eff_size)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_SIZE_MISMATCH;
                     end else begin
                        stack_cmd.pop = 1'b1;
                        state_in      = S_ALLOC_MUL;
                     end
                  end
                  ACT_FREE: begin
                     if (req_block_length != LEN_W'(eff_size)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_SIZE_MISMATCH;
                     end else if (req_block_address < base_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_OUT_OF_RANGE;
                     end else begin
                        state_in = S_CALC;
                     end
                  end
                  ACT_QUERY: begin
                     state_in = S_CALC;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_ALLOC_MUL: begin
            mul_in   = ADDR_W'(mul_prod);
            state_in = S_ALLOC_ADD;
         end
         S_ALLOC_ADD: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_OK;
            rsp_gaddr_in  = base_ff + mul_ff;
            rsp_gbytes_in = eff_size;
            state_in      = S_IDLE;
         end
         S_CALC: begin
            offset_in = addr_ff - base_ff;
            mul_in    = ADDR_W'(mul_prod);
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (action_ff == ACT_QUERY) begin
               rsp_strobe_in  = 1'b1;
               rsp_in_pool_in = !below_ff && (offset_ff < mul_ff);
               state_in       = S_IDLE;
            end else if (offset_ff >= mul_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OUT_OF_RANGE;
               state_in      = S_IDLE;
            end else if (stack_stat.full) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_STACK_FULL;
               state_in      = S_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               stack_cmd.push = 1'b1;
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = ST_OK;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         base_ff       <= '0;
         bytes_ff      <= SIZE_W'(RESET_SIZE);
         count_ff      <= COUNT_W'(RST_COUNT);
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         base_ff       <= base_in;
         bytes_ff      <= bytes_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      addr_ff        <= addr_in;
      below_ff       <= below_in;
      offset_ff      <= offset_in;
      mul_ff         <= mul_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_gaddr_ff   <= rsp_gaddr_in;
      rsp_gbytes_ff  <= rsp_gbytes_in;
      rsp_in_pool_ff <= rsp_in_pool_in;
   end

   fbpa_stack #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_stack (
      .clock       (clock),
      .reset       (reset),
      .cmd         (stack_cmd),
      .block_count (count_ff),
      .push_data   (push_data),
      .pop_data    (pop_data),
      .stat        (stack_stat)
   );

   fbpa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset_ff[PROD_W-1:0]),
      .divisor  (eff_size),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_gaddr_ff;
   assign rsp_granted_bytes   = rsp_gbytes_ff;
   assign rsp_in_pool         = rsp_in_pool_ff;

   `FBPA_ASSERT_NOW(a_pop_not_empty, clock, reset, stack_cmd.pop, !stack_stat.empty, "pop from empty free stack")
   `FBPA_ASSERT_NOW(a_push_not_full, clock, reset, stack_cmd.push, !stack_stat.full, "push onto full free stack")
   `FBPA_ASSERT_NEXT(a_free_result, clock, reset, (state_ff == S_DIVIDE) && div_done, rsp_strobe && (rsp_status == ST_OK), "free did not report ok")

endmodule

`default_nettype wire
